/* rtl/edge_cost_sort_statistics_assert.svh */
// ----------------------------------------------------------------------------
// Edge cost statistics assertion macros
// Shared property forms for the edge cost statistics block.
// ----------------------------------------------------------------------------
`ifndef EDGE_COST_SORT_STATISTICS_ASSERT_SVH
`define EDGE_COST_SORT_STATISTICS_ASSERT_SVH

// same-cycle implication
`define ECSS_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ecss assertion failed");

// next-cycle implication
`define ECSS_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ecss assertion failed");

`endif

/* rtl/ecss_pkg.sv */
// ----------------------------------------------------------------------------
// Edge cost statistics package
// Field widths, sequencer states and the saturating scale helper.
// ----------------------------------------------------------------------------
`default_nettype none
package ecss_pkg;
	localparam int COST_W  = 16;
	localparam int NC_W    = 7;
	localparam int SC_W    = 22;
	localparam int EDGES_W = 12;
	localparam int PROD_W  = COST_W + NC_W;
	localparam logic [PROD_W-1:0] SCALE_MAX = PROD_W'(4194303);

	typedef enum logic [4:0] {
		S_LOAD, S_CHECK, S_NEXT, S_PIV_RD, S_PIV_WT, S_J_RD, S_J_WT, S_I_WT,
		S_J_WR, S_FIN_WT, S_FIN_WR, S_SEL_RD, S_SEL_WT, S_MAX_RD, S_MAX_WT,
		S_DIV_GO, S_DIV_WT, S_MUL_A, S_MUL_M, S_MUL_D, S_DONE
	} fsm_t;

	function automatic logic [SC_W-1:0] sat_scale(input logic [PROD_W-1:0] p);
		sat_scale = (p > SCALE_MAX) ? {SC_W{1'b1}} : p[SC_W-1:0];
	endfunction
endpackage
`default_nettype wire

/* rtl/ecss_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module ecss_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2048
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

/* rtl/ecss_div.sv */
// ----------------------------------------------------------------------------
// Iterative divider
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module ecss_div #(
	parameter int NW = 27,
	parameter int DW = 12
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [NW-1:0] dividend,
	input  wire logic [DW-1:0] divisor,
	output logic               done,
	output logic [NW-1:0]      quotient
);
	localparam int CNT_W = $clog2(NW + 1);

	logic [DW:0]      rem_q;
	logic [NW-1:0]    quo_q;
	logic [DW-1:0]    dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic [DW:0]      rem_sh;
	logic             fits;

	assign rem_sh   = {rem_q[DW-1:0], quo_q[NW-1]};
	assign fits     = rem_sh >= {1'b0, dvs_q};
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
			quo_q <= {quo_q[NW-2:0], fits};
		end
	end
endmodule
`default_nettype wire

/* rtl/edge_cost_sort_statistics.sv */
// ----------------------------------------------------------------------------
// Edge cost statistics
// Loads edge costs, selects the median in place and reports scaled stats.
// ----------------------------------------------------------------------------
// Input stream: s_tdata carries one edge cost, s_tlast marks the final edge
// of a batch. Costs load at one transfer per cycle into the cost RAM while
// the minimum, total and count update alongside.
// The last transfer closes the batch: s_tready drops while a quickselect
// (Lomuto partitions on the single RAM, each read waiting on registered data), a
// max scan for an even count, a bit-serial divide (one bit per cycle over
// the total width) and three multiplies run. The partition loop dominates
// the work: O(n) on average and O(n^2) in the worst case.
// The result waits in an output register; loading of the next batch goes
// on while the receiver stalls, and after the next last edge the block
// finishes its work, then waits not ready until that register is free.
// Reset empties the batch, sets node_count to 1 and drops m_tvalid; the
// RAM holds no reset state. An overflow or empty batch gives error_flag.
// cfg_we writes node_count in any idle cycle.
// ----------------------------------------------------------------------------
`default_nettype none
`include "edge_cost_sort_statistics_assert.svh"
module edge_cost_sort_statistics #(
	parameter int MAX_EDGES = 2048
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [6:0]  cfg_wdata,     // node_count
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,       // edge_cost
	input  wire logic        s_tlast,       // last_edge
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [79:0]      m_tdata,       // average_scaled, minimum_scaled,
	                                        // median_scaled, edges_seen, zero pad
	output logic             m_tuser        // error_flag
);
	localparam int AW = $clog2(MAX_EDGES);
	localparam int CW = $clog2(MAX_EDGES + 1);
	localparam int TW = ecss_pkg::COST_W + CW;
	localparam int CB = ecss_pkg::COST_W;

	ecss_pkg::fsm_t fsm_q, fsm_d;

	logic [ecss_pkg::NC_W-1:0] nc_q;
	logic [CW-1:0]  cnt_q;
	logic [CB-1:0]  min_q;
	logic [TW-1:0]  tot_q;
	logic           ovf_q;
	logic [AW-1:0]  lo_q, hi_q, i_q, j_q, k_q, m_q;
	logic [CB-1:0]  piv_q, vj_q, vi_q, kval_q, mx_q, med_q, avg_q;
	logic [ecss_pkg::PROD_W-1:0] prod_q;
	logic [ecss_pkg::SC_W-1:0]   avg_res_q, min_res_q;
	logic           err_q;
	logic           out_v_q;
	logic [79:0]    out_d_q;
	logic           out_e_q;

	logic           ram_we;
	logic [AW-1:0]  ram_wa, ram_ra;
	logic [CB-1:0]  ram_wd, ram_rd;
	logic           div_go, div_done;
	logic [TW-1:0]  div_q;
	logic           acc, out_free, room;
	logic [CB-1:0]  mul_a;

	assign acc      = s_tvalid && s_tready;
	assign out_free = !out_v_q || m_tready;
	assign room     = cnt_q < CW'(MAX_EDGES);
	assign s_tready = fsm_q == ecss_pkg::S_LOAD;
	assign m_tvalid = out_v_q;
	assign m_tdata  = out_d_q;
	assign m_tuser  = out_e_q;
	assign div_go   = fsm_q == ecss_pkg::S_DIV_GO;

	ecss_ram #(.WIDTH(CB), .DEPTH(MAX_EDGES)) u_ram (
		.clk(clk), .we(ram_we), .waddr(ram_wa), .wdata(ram_wd),
		.raddr(ram_ra), .rdata(ram_rd)
	);

	ecss_div #(.NW(TW), .DW(CW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_go), .dividend(tot_q),
		.divisor(cnt_q), .done(div_done), .quotient(div_q)
	);

	always_comb begin
		fsm_d = fsm_q;
		case (fsm_q)
			ecss_pkg::S_LOAD:   if (acc && s_tlast) fsm_d = ecss_pkg::S_CHECK;
			ecss_pkg::S_CHECK:  fsm_d = (ovf_q || cnt_q == '0) ? ecss_pkg::S_DONE
			                          : ecss_pkg::S_NEXT;
			ecss_pkg::S_NEXT:   fsm_d = (lo_q == hi_q) ? ecss_pkg::S_SEL_RD
			                          : ecss_pkg::S_PIV_RD;
			ecss_pkg::S_PIV_RD: fsm_d = ecss_pkg::S_PIV_WT;
			ecss_pkg::S_PIV_WT: fsm_d = ecss_pkg::S_J_RD;
			ecss_pkg::S_J_RD:   fsm_d = (j_q == hi_q) ? ecss_pkg::S_FIN_WT
			                          : ecss_pkg::S_J_WT;
			ecss_pkg::S_J_WT: begin
				if (ram_rd <= piv_q && i_q != j_q) fsm_d = ecss_pkg::S_I_WT;
				else fsm_d = ecss_pkg::S_J_RD;
			end
			ecss_pkg::S_I_WT:   fsm_d = ecss_pkg::S_J_WR;
			ecss_pkg::S_J_WR:   fsm_d = ecss_pkg::S_J_RD;
			ecss_pkg::S_FIN_WT: fsm_d = ecss_pkg::S_FIN_WR;
			ecss_pkg::S_FIN_WR: begin
				if (i_q != k_q) fsm_d = ecss_pkg::S_NEXT;
				else if (cnt_q[0]) fsm_d = ecss_pkg::S_DIV_GO;
				else fsm_d = ecss_pkg::S_MAX_RD;
			end
			ecss_pkg::S_SEL_RD: fsm_d = ecss_pkg::S_SEL_WT;
			ecss_pkg::S_SEL_WT: fsm_d = cnt_q[0] ? ecss_pkg::S_DIV_GO : ecss_pkg::S_MAX_RD;
			ecss_pkg::S_MAX_RD: fsm_d = ecss_pkg::S_MAX_WT;
			ecss_pkg::S_MAX_WT: fsm_d = (m_q == k_q - 1'b1) ? ecss_pkg::S_DIV_GO
			                          : ecss_pkg::S_MAX_RD;
			ecss_pkg::S_DIV_GO: fsm_d = ecss_pkg::S_DIV_WT;
			ecss_pkg::S_DIV_WT: if (div_done) fsm_d = ecss_pkg::S_MUL_A;
			ecss_pkg::S_MUL_A:  fsm_d = ecss_pkg::S_MUL_M;
			ecss_pkg::S_MUL_M:  fsm_d = ecss_pkg::S_MUL_D;
			ecss_pkg::S_MUL_D:  fsm_d = ecss_pkg::S_DONE;
			ecss_pkg::S_DONE:   if (out_free) fsm_d = ecss_pkg::S_LOAD;
			default:            fsm_d = ecss_pkg::S_LOAD;
		endcase
	end

	always_comb begin
		ram_we = 1'b0;
		ram_wa = i_q;
		ram_wd = vj_q;
		ram_ra = j_q;
		mul_a  = avg_q;
		case (fsm_q)
			ecss_pkg::S_LOAD: begin
				ram_we = acc && room;
				ram_wa = cnt_q[AW-1:0];
				ram_wd = s_tdata;
			end
			ecss_pkg::S_PIV_RD: ram_ra = hi_q;
			ecss_pkg::S_J_RD:   ram_ra = (j_q == hi_q) ? i_q : j_q;
			ecss_pkg::S_J_WT:   ram_ra = i_q;
			ecss_pkg::S_I_WT:   ram_we = 1'b1;
			ecss_pkg::S_J_WR: begin
				ram_we = 1'b1;
				ram_wa = j_q;
				ram_wd = vi_q;
			end
			ecss_pkg::S_FIN_WT: begin
				ram_we = 1'b1;
				ram_wd = piv_q;
			end
			ecss_pkg::S_FIN_WR: begin
				ram_we = 1'b1;
				ram_wa = hi_q;
				ram_wd = vi_q;
			end
			ecss_pkg::S_SEL_RD: ram_ra = lo_q;
			ecss_pkg::S_MAX_RD: ram_ra = m_q;
			ecss_pkg::S_MUL_M:  mul_a = min_q;
			ecss_pkg::S_MUL_D,
			ecss_pkg::S_DONE:   mul_a = med_q;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsm_q   <= ecss_pkg::S_LOAD;
			nc_q    <= ecss_pkg::NC_W'(1);
			cnt_q   <= '0;
			min_q   <= '1;
			tot_q   <= '0;
			ovf_q   <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			fsm_q <= fsm_d;
			if (cfg_we) nc_q <= cfg_wdata;
			if (acc) begin
				if (room) begin
					cnt_q <= cnt_q + 1'b1;
					tot_q <= tot_q + TW'(s_tdata);
					if (s_tdata < min_q) min_q <= s_tdata;
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (fsm_q == ecss_pkg::S_DONE && out_free) begin
				out_v_q <= 1'b1;
				cnt_q   <= '0;
				min_q   <= '1;
				tot_q   <= '0;
				ovf_q   <= 1'b0;
			end else if (m_tready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= ecss_pkg::PROD_W'(mul_a) * ecss_pkg::PROD_W'(nc_q);
		case (fsm_q)
			ecss_pkg::S_CHECK: begin
				err_q <= ovf_q || cnt_q == '0;
				lo_q  <= '0;
				hi_q  <= AW'(cnt_q - 1'b1);
				k_q   <= AW'(cnt_q >> 1);
			end
			ecss_pkg::S_PIV_WT: begin
				piv_q <= ram_rd;
				i_q   <= lo_q;
				j_q   <= lo_q;
			end
			ecss_pkg::S_J_WT: begin
				vj_q <= ram_rd;
				if (ram_rd <= piv_q && i_q == j_q) begin
					i_q <= i_q + 1'b1;
					j_q <= j_q + 1'b1;
				end else if (ram_rd > piv_q) begin
					j_q <= j_q + 1'b1;
				end
			end
			ecss_pkg::S_I_WT:   vi_q <= ram_rd;
			ecss_pkg::S_J_WR: begin
				i_q <= i_q + 1'b1;
				j_q <= j_q + 1'b1;
			end
			ecss_pkg::S_FIN_WT: vi_q <= ram_rd;
			ecss_pkg::S_FIN_WR: begin
				kval_q <= piv_q;
				mx_q   <= '0;
				m_q    <= '0;
				if (k_q < i_q) hi_q <= i_q - 1'b1;
				else if (k_q > i_q) lo_q <= i_q + 1'b1;
			end
			ecss_pkg::S_SEL_WT: begin
				kval_q <= ram_rd;
				mx_q   <= '0;
				m_q    <= '0;
			end
			ecss_pkg::S_MAX_WT: begin
				if (ram_rd > mx_q) mx_q <= ram_rd;
				m_q <= m_q + 1'b1;
			end
			ecss_pkg::S_DIV_GO: begin
				if (cnt_q[0]) med_q <= kval_q;
				else med_q <= CB'(({1'b0, kval_q} + {1'b0, mx_q}) >> 1);
			end
			ecss_pkg::S_DIV_WT: avg_q <= div_q[CB-1:0];
			ecss_pkg::S_MUL_M:  avg_res_q <= ecss_pkg::sat_scale(prod_q);
			ecss_pkg::S_MUL_D:  min_res_q <= ecss_pkg::sat_scale(prod_q);
			ecss_pkg::S_DONE: begin
				if (out_free) begin
					out_e_q <= err_q;
					if (err_q) out_d_q <= '0;
					else out_d_q <= {2'b00, ecss_pkg::EDGES_W'(cnt_q),
					                 ecss_pkg::sat_scale(prod_q), min_res_q, avg_res_q};
				end
			end
			default: begin
			end
		endcase
	end

	`ECSS_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_q <= CW'(MAX_EDGES))
	`ECSS_ASSERT_IMP(a_err_zero, m_tvalid && m_tuser, m_tdata == '0)
	`ECSS_ASSERT_IMP(a_k_in_range, fsm_q == ecss_pkg::S_PIV_RD, lo_q <= k_q && k_q <= hi_q)
	`ECSS_ASSERT_NXT(a_last_starts, acc && s_tlast, fsm_q == ecss_pkg::S_CHECK)
endmodule
`default_nettype wire

/* test/edge_cost_sort_statistics_checker.sv */
// ----------------------------------------------------------------------------
// Edge cost statistics checker
// Watches the edge and result streams, computes the expected statistics for
// every closed batch and compares each result transfer field by field.
// ----------------------------------------------------------------------------
module edge_cost_sort_statistics_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [6:0]  cfg_wdata,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [15:0] s_tdata,
	input  logic        s_tlast,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [79:0] m_tdata,
	input  logic        m_tuser,
	output int          pending,
	output int          errors
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_EDGES = 2048;
	localparam int SAT_LIMIT = 4194303;

	typedef struct {
		logic [21:0] average;
		logic [21:0] minimum;
		logic [21:0] median;
		logic [11:0] edges;
		logic        err;
	} stats_t;

	stats_t      stats_q[$];
	logic [15:0] costs[MAX_EDGES];
	int          edge_cnt;
	logic [15:0] min_cost;
	longint      cost_sum;
	logic        overflow;
	logic [6:0]  nodes;
	int          fail_cnt;

	function automatic logic [21:0] scaled(input longint v, input logic [6:0] nc);
		longint p;
		p = v * nc;
		scaled = (p > SAT_LIMIT) ? 22'(SAT_LIMIT) : 22'(p);
	endfunction

	task automatic close_batch();
		stats_t      r;
		logic [15:0] v;
		int          m;
		longint      mid;
		if (edge_cnt == 0 || overflow) begin
			r = '{default: '0};
			r.err = 1'b1;
		end else begin
			for (int k = 1; k < edge_cnt; k++) begin
				v = costs[k];
				m = k;
				while (m > 0 && costs[m-1] > v) begin
					costs[m] = costs[m-1];
					m--;
				end
				costs[m] = v;
			end
			if (edge_cnt % 2 == 0)
				mid = (longint'(costs[edge_cnt/2-1]) + costs[edge_cnt/2]) / 2;
			else
				mid = costs[edge_cnt/2];
			r.average = scaled(cost_sum / edge_cnt, nodes);
			r.minimum = scaled(min_cost, nodes);
			r.median  = scaled(mid, nodes);
			r.edges   = 12'(edge_cnt);
			r.err     = 1'b0;
		end
		stats_q.push_back(r);
		edge_cnt = 0;
		min_cost = 16'hFFFF;
		cost_sum = 0;
		overflow = 1'b0;
	endtask

	task automatic report(input string what, input longint exp_v, input longint act_v);
		fail_cnt++;
		if (fail_cnt <= 10)
			$display("mismatch %s: expected %0d, got %0d at %0t", what, exp_v, act_v, $realtime);
	endtask

	always @(posedge clk or negedge arst_n) begin
		stats_t r;
		if (!arst_n) begin
			stats_q.delete();
			edge_cnt = 0;
			min_cost = 16'hFFFF;
			cost_sum = 0;
			overflow = 1'b0;
			nodes    = 7'd1;
			fail_cnt = 0;
			pending  <= 0;
			errors   <= 0;
		end else begin
			if (cfg_we)
				nodes = cfg_wdata;
			if (m_tvalid && m_tready) begin
				if (stats_q.size() == 0) begin
					report("unexpected result transfer", 0, 1);
				end else begin
					r = stats_q.pop_front();
					if (m_tdata[21:0] !== r.average)
						report("average_scaled", r.average, m_tdata[21:0]);
					if (m_tdata[43:22] !== r.minimum)
						report("minimum_scaled", r.minimum, m_tdata[43:22]);
					if (m_tdata[65:44] !== r.median)
						report("median_scaled", r.median, m_tdata[65:44]);
					if (m_tdata[77:66] !== r.edges)
						report("edges_seen", r.edges, m_tdata[77:66]);
					if (m_tuser !== r.err)
						report("error_flag", r.err, m_tuser);
				end
			end
			if (s_tvalid && s_tready) begin
				if (edge_cnt < MAX_EDGES) begin
					costs[edge_cnt] = s_tdata;
					edge_cnt++;
					if (s_tdata < min_cost)
						min_cost = s_tdata;
					cost_sum += s_tdata;
				end else begin
					overflow = 1'b1;
				end
				if (s_tlast)
					close_batch();
			end
			pending <= stats_q.size();
			errors  <= fail_cnt;
		end
	end
endmodule

/* test/edge_cost_sort_statistics_test.sv */
// ----------------------------------------------------------------------------
// Edge cost statistics testbench
// Drives batches of edge costs under random gaps and stalls, rescales with
// several node counts, and takes the verdict from the checker's count.
// ----------------------------------------------------------------------------
module edge_cost_sort_statistics_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DRAIN_CYCLES = 64;
	localparam int MODE_RANDOM  = 0;
	localparam int MODE_NARROW  = 1;
	localparam int MODE_EXTREME = 2;
	localparam int MODE_RISING  = 3;
	localparam int MODE_FALLING = 4;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [6:0]  cfg_wdata;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [79:0] m_tdata;
	logic        m_tuser;
	int          pending;
	int          errors;

	logic        hold_go;
	logic        hold_used;
	int          hold_cnt;
	int          rx_cycle;
	bit          tx_quiet;
	int          batch_cnt;
	int          item_cnt;

	edge_cost_sort_statistics u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	edge_cost_sort_statistics_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.pending   (pending),
		.errors    (errors)
	);

	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// receiver: random stalls, one quiet window, one long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready  <= 1'b0;
			hold_cnt  <= 0;
			hold_used <= 1'b0;
			rx_cycle  <= 0;
		end else begin
			rx_cycle <= rx_cycle + 1;
			if (hold_cnt > 0) begin
				m_tready <= 1'b0;
				hold_cnt <= hold_cnt - 1;
			end else if (hold_go && !hold_used) begin
				m_tready  <= 1'b0;
				hold_cnt  <= 400;
				hold_used <= 1'b1;
			end else if (rx_cycle > 3000 && rx_cycle < 4500) begin
				m_tready <= 1'b1;
			end else begin
				m_tready <= ($urandom_range(99) >= 36);
			end
		end
	end

	initial begin
		#20ms;
		$display("timeout");
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	task automatic push_edge(input logic [15:0] cost, input logic last);
		if (!tx_quiet) begin
			while ($urandom_range(99) < 36) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tdata  <= cost;
		s_tlast  <= last;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		item_cnt++;
	endtask

	function automatic logic [15:0] pick_cost(input int mode, input int k, input int n);
		case (mode)
			MODE_NARROW:  pick_cost = 16'($urandom_range(7));
			MODE_EXTREME: pick_cost = $urandom_range(1) ? 16'hFFFF : 16'h0000;
			MODE_RISING:  pick_cost = 16'(k * 97);
			MODE_FALLING: pick_cost = 16'((n - k) * 97);
			default:      pick_cost = 16'($urandom);
		endcase
	endfunction

	task automatic send_batch(input int n, input int mode);
		for (int k = 0; k < n; k++)
			push_edge(pick_cost(mode, k, n), k == n - 1);
		batch_cnt++;
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_nodes(input logic [6:0] nc);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= nc;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	initial begin
		int n;
		int mode;
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_wdata = 7'd1;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tlast   = 1'b0;
		hold_go   = 1'b0;
		tx_quiet  = 1'b0;
		batch_cnt = 0;
		item_cnt  = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: single edge, pairs, extremes, ordered runs, duplicates
		push_edge(16'hFFFF, 1'b1); batch_cnt++;
		push_edge(16'h0000, 1'b1); batch_cnt++;
		push_edge(16'hFFFF, 1'b0); push_edge(16'hFFFE, 1'b1); batch_cnt++;
		push_edge(16'h0001, 1'b0); push_edge(16'h0000, 1'b1); batch_cnt++;
		send_batch(5, MODE_RISING);
		send_batch(5, MODE_FALLING);
		send_batch(4, MODE_NARROW);
		set_nodes(7'd64);
		send_batch(3, MODE_EXTREME);
		push_edge(16'hFFFF, 1'b1); batch_cnt++;
		set_nodes(7'd127);
		push_edge(16'hFFFF, 1'b0); push_edge(16'h1234, 1'b1); batch_cnt++;
		set_nodes(7'd0);
		send_batch(3, MODE_RANDOM);

		// random batches under several node counts
		for (int phase = 0; phase < 8; phase++) begin
			case (phase)
				0:       set_nodes(7'd1);
				1:       set_nodes(7'd64);
				2:       set_nodes(7'd127);
				default: set_nodes(7'($urandom_range(127)));
			endcase
			tx_quiet = (phase == 3);
			if (phase == 4)
				hold_go <= 1'b1;
			for (int b = 0; b < 10; b++) begin
				n    = ($urandom_range(9) == 0) ? $urandom_range(40, 17) : $urandom_range(16, 1);
				mode = $urandom_range(MODE_FALLING, MODE_RANDOM);
				send_batch(n, mode);
			end
		end
		tx_quiet = 1'b0;

		drain();
		$display("%0d batches, %0d edge transfers, node counts 0 to 127", batch_cnt, item_cnt);
		$display("covered ordered, narrow and extreme costs, long receiver hold-off, idle pauses");
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule

/* sim.f */
+incdir+rtl
rtl/ecss_pkg.sv
rtl/ecss_ram.sv
rtl/ecss_div.sv
rtl/edge_cost_sort_statistics.sv
test/edge_cost_sort_statistics_checker.sv
test/edge_cost_sort_statistics_test.sv
